/* hw/rtl/bba_pkg.sv */
// Shared definitions for the bitmap block allocator: field widths, opcodes,
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package bba_pkg;

   localparam int DEF_MAX_BLOCKS = 65536;
   localparam int DEF_WORD_BITS  = 32;

   // Block numbers are 16 bits wide, so no more than this many are addressable.
   localparam int BLOCK_SPACE = 65536;

   localparam int OPCODE_W   = 3;
   localparam int BLOCK_W    = 16;
   localparam int BITVAL_W   = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 17;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   // Shift used by the reciprocal multiply that splits a block number into word and bit.
   localparam int DIV_SHIFT = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 17'd65536;
   localparam logic [COUNT_W-1:0] TOTAL_RESET = 17'd65536;

   localparam logic [OPCODE_W-1:0] OP_ALLOC = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_WBIT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_RBIT  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_INIT  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADBIT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

   // Kind of completion the datapath commits when the controller finishes an operation.
   typedef enum logic [3:0] {
      FIN_NONE   = 4'd0,
      FIN_NOFREE = 4'd1,
      FIN_RANGE  = 4'd2,
      FIN_BADBIT = 4'd3,
      FIN_ALLOC  = 4'd4,
      FIN_FREE   = 4'd5,
      FIN_WBIT   = 4'd6,
      FIN_RBIT   = 4'd7,
      FIN_INIT   = 4'd8
   } fin_type;

   typedef struct packed {
      logic    capture;
      logic    clear_start;
      logic    clear_step;
      logic    scan_start;
      logic    scan_next;
      logic    div_mul;
      logic    div_quot;
      logic    div_rem;
      logic    div_fix;
      logic    finish;
      fin_type fin;
   } cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                count_zero;
      logic                out_of_range;
      logic                bad_bit;
      logic                base_ge_lim;
      logic                found;
      logic                clear_last;
   } stat_type;

endpackage

`default_nettype wire

/* hw/rtl/bitmap_block_allocator.sv */
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_ctrl and bba_datapath (which holds bba_ram).
//
// The allocator keeps one occupancy bit per block in a RAM of WORD_BITS-wide
// words and a 17-bit free count. Each request transaction produces exactly one
// response transaction. Free, write bit and read bit split the block number into
// word and bit (reciprocal multiply, quotient, remainder, correction), followed
// by a registered RAM read. Allocate reads words on the single RAM port,
// starting at the lowest word that can still hold a clear bit, so a fill in
// block order mostly reads only that word; a search that runs into the limit
// without finding a clear bit ends with a final limit check. Init and errors
// found up front go straight to the response, except that init first clears
// the RAM one word per cycle. The same clearing pass runs after reset, during
// which req_tready stays low; the configuration port is always ready. A
// finished response waits in an output register, so the next request is
// accepted while it is still pending.
// total_blocks should only be written while no request is in flight.
`default_nettype none

module bitmap_block_allocator #(
   parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
   parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel.
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: block_number [15:0], bit_value [23:16].
   input  wire logic [bba_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: opcode [2:0].
   input  wire logic [bba_pkg::OPCODE_W-1:0]   req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // Fields from bit 0: result_block [15:0], read_bit [16], free_blocks [33:17],
   // zero fill [39:34].
   output logic      [bba_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Fields from bit 0: status [1:0].
   output logic      [bba_pkg::STATUS_W-1:0]   rsp_tuser,
   // Configuration write channel: total_blocks.
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bba_pkg::COUNT_W-1:0]    csr_data
);

   import bba_pkg::*;

   // Blocks that can be addressed at all, and the RAM shape that holds them.
   localparam int USED_BLOCKS = (MAX_BLOCKS < BLOCK_SPACE) ? MAX_BLOCKS : BLOCK_SPACE;
   localparam int DEPTH       = (USED_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type              cmd;
   stat_type             st;
   logic [STATUS_W-1:0]  rsp_status;
   logic [BLOCK_W-1:0]   rsp_block;
   logic                 rsp_bit;
   logic [COUNT_W-1:0]   rsp_free;

   // The register file has a single register and never stalls a write.
   assign csr_ready = 1'b1;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .st        (st)
   );

   bba_datapath #(
      .WORD_BITS   (WORD_BITS),
      .USED_BLOCKS (USED_BLOCKS),
      .DEPTH       (DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_opcode (req_tuser),
      .req_block  (req_tdata[15:0]),
      .req_bitval (req_tdata[23:16]),
      .cfg_we     (csr_valid),
      .cfg_data   (csr_data),
      .cmd        (cmd),
      .st         (st),
      .rsp_status (rsp_status),
      .rsp_block  (rsp_block),
      .rsp_bit    (rsp_bit),
      .rsp_free   (rsp_free)
   );

   assign rsp_tdata = {6'b0, rsp_free, rsp_bit, rsp_block};
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

/* hw/rtl/bba_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bba_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/bba_ctrl.sv */
// Sequencing state machine of the bitmap block allocator.
// Depends on bba_pkg for the command and status structs and the opcodes.
`default_nettype none

module bba_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bba_pkg::cmd_type       cmd,
   input  wire bba_pkg::stat_type st
);

   import bba_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR  = 10'b0000000001,
      S_IDLE   = 10'b0000000010,
      S_DECODE = 10'b0000000100,
      S_SLIM   = 10'b0000001000,
      S_SCHK   = 10'b0000010000,
      S_DIV1   = 10'b0000100000,
      S_DIV2   = 10'b0001000000,
      S_DIV3   = 10'b0010000000,
      S_RREAD  = 10'b0100000000,
      S_FIN    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   fin_type   fin_ff, fin_in;
   logic      init_ff, init_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      fin_in    = fin_ff;
      init_in   = init_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.fin   = FIN_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (st.clear_last) begin
               if (init_ff) begin
                  fin_in   = FIN_INIT;
                  state_in = S_FIN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.div_mul = 1'b1;
            unique case (st.op)
               OP_ALLOC: begin
                  if (st.count_zero) begin
                     fin_in   = FIN_NOFREE;
                     state_in = S_FIN;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SLIM;
                  end
               end
               OP_FREE: begin
                  if (st.out_of_range) begin
                     fin_in   = FIN_RANGE;
                     state_in = S_FIN;
                  end else begin
                     fin_in   = FIN_FREE;
                     state_in = S_DIV1;
                  end
               end
               OP_WBIT: begin
                  if (st.out_of_range) begin
                     fin_in   = FIN_RANGE;
                     state_in = S_FIN;
                  end else if (st.bad_bit) begin
                     fin_in   = FIN_BADBIT;
                     state_in = S_FIN;
                  end else begin
                     fin_in   = FIN_WBIT;
                     state_in = S_DIV1;
                  end
               end
               OP_RBIT: begin
                  if (st.out_of_range) begin
                     fin_in   = FIN_RANGE;
                     state_in = S_FIN;
                  end else begin
                     fin_in   = FIN_RBIT;
                     state_in = S_DIV1;
                  end
               end
               OP_INIT: begin
                  init_in         = 1'b1;
                  cmd.clear_start = 1'b1;
                  state_in        = S_CLEAR;
               end
               default: begin
                  fin_in   = FIN_NONE;
                  state_in = S_FIN;
               end
            endcase
         end
         S_SLIM: begin
            if (st.base_ge_lim) begin
               fin_in   = FIN_NOFREE;
               state_in = S_FIN;
            end else begin
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (st.found) begin
               fin_in   = FIN_ALLOC;
               state_in = S_FIN;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SLIM;
            end
         end
         S_DIV1: begin
            cmd.div_quot = 1'b1;
            state_in     = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_rem = 1'b1;
            state_in    = S_DIV3;
         end
         S_DIV3: begin
            cmd.div_fix = 1'b1;
            state_in    = S_RREAD;
         end
         S_RREAD: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               cmd.fin    = fin_ff;
               init_in    = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         fin_ff       <= FIN_NONE;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hw/rtl/bba_datapath.sv */
// Datapath of the bitmap block allocator: bitmap RAM, free count, search
// pointer and hint, block-number split, and the result register.
// Depends on bba_pkg and bba_ram.
`default_nettype none

module bba_datapath #(
   parameter int WORD_BITS   = 32,
   parameter int USED_BLOCKS = 65536,
   parameter int DEPTH       = 2048,
   parameter int ADDR_W      = 11
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [bba_pkg::OPCODE_W-1:0]    req_opcode,
   input  wire logic [bba_pkg::BLOCK_W-1:0]     req_block,
   input  wire logic [bba_pkg::BITVAL_W-1:0]    req_bitval,
   input  wire logic                            cfg_we,
   input  wire logic [bba_pkg::COUNT_W-1:0]     cfg_data,
   input  wire bba_pkg::cmd_type                cmd,
   output bba_pkg::stat_type                    st,
   output logic      [bba_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [bba_pkg::BLOCK_W-1:0]     rsp_block,
   output logic                                 rsp_bit,
   output logic      [bba_pkg::COUNT_W-1:0]     rsp_free
);

   import bba_pkg::*;

   localparam int BW      = $clog2(WORD_BITS);
   localparam int REM_W   = $clog2(2 * WORD_BITS);
   localparam int RECIP   = (1 << DIV_SHIFT) / WORD_BITS;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = BLOCK_W + RECIP_W;

   logic [OPCODE_W-1:0]  op_ff;
   logic [BLOCK_W-1:0]   blk_ff;
   logic [BITVAL_W-1:0]  bv_ff;
   logic [COUNT_W-1:0]   total_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]    word_ff;
   logic [COUNT_W-1:0]   base_ff;
   logic [ADDR_W-1:0]    hint_ff, hint_in;
   logic [COUNT_W-1:0]   hint_base_ff, hint_base_in;
   logic [PROD_W-1:0]    prod_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [STATUS_W-1:0]  rsp_status_ff, status_in;
   logic [BLOCK_W-1:0]   rsp_block_ff, block_in;
   logic                 rsp_bit_ff, bit_in;
   logic [COUNT_W-1:0]   rsp_free_ff;

   logic [COUNT_W-1:0]   lim;
   logic [COUNT_W-1:0]   span;
   logic [COUNT_W-1:0]   free_base;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] in_mask;
   logic [WORD_BITS-1:0] avail;
   logic [BW-1:0]        first_k;
   logic [BW-1:0]        bidx;
   logic [WORD_BITS-1:0] oh_k;
   logic [WORD_BITS-1:0] oh_b;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;

   function automatic logic [BW-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BW-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BW'(i);
         end
      end
      return idx;
   endfunction

   // Active limit: the configured count, capped by the managed address space.
   assign lim = (total_ff > COUNT_W'(USED_BLOCKS)) ? COUNT_W'(USED_BLOCKS) : total_ff;

   // Search: only bits below the limit are candidates.
   assign span = lim - base_ff;
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         in_mask[i] = COUNT_W'(i) < span;
      end
   end
   assign avail   = ~rd_data & in_mask;
   assign first_k = lowest_set(avail);
   assign oh_k    = WORD_BITS'(1) << first_k;

   assign bidx      = rem_ff[BW-1:0];
   assign oh_b      = WORD_BITS'(1) << bidx;
   assign free_base = {1'b0, blk_ff} - COUNT_W'(rem_ff);

   assign st.op           = op_ff;
   assign st.count_zero   = count_ff == '0;
   assign st.out_of_range = {1'b0, blk_ff} >= lim;
   assign st.bad_bit      = bv_ff > BITVAL_W'(1);
   assign st.base_ge_lim  = base_ff >= lim;
   assign st.found        = |avail;
   assign st.clear_last   = word_ff == ADDR_W'(DEPTH - 1);

   // Commit of a finished operation; also the RAM write of each clearing step.
   always_comb begin
      count_in     = count_ff;
      hint_in      = hint_ff;
      hint_base_in = hint_base_ff;
      status_in    = ST_OK;
      block_in     = '0;
      bit_in       = 1'b0;
      wr_en        = cmd.clear_step;
      wr_data      = '0;
      if (cmd.finish) begin
         case (cmd.fin)
            FIN_NOFREE: status_in = ST_NOFREE;
            FIN_RANGE:  status_in = ST_RANGE;
            FIN_BADBIT: status_in = ST_BADBIT;
            FIN_ALLOC: begin
               count_in     = count_ff - COUNT_W'(1);
               hint_in      = word_ff;
               hint_base_in = base_ff;
               block_in     = BLOCK_W'(base_ff + COUNT_W'(first_k));
               wr_en        = 1'b1;
               wr_data      = rd_data | oh_k;
            end
            FIN_FREE: begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               if (word_ff < hint_ff) begin
                  hint_in      = word_ff;
                  hint_base_in = free_base;
               end
               block_in = blk_ff;
               wr_en    = 1'b1;
               wr_data  = rd_data & ~oh_b;
            end
            FIN_WBIT: begin
               if (!bv_ff[0] && (word_ff < hint_ff)) begin
                  hint_in      = word_ff;
                  hint_base_in = free_base;
               end
               wr_en   = 1'b1;
               wr_data = bv_ff[0] ? (rd_data | oh_b) : (rd_data & ~oh_b);
            end
            FIN_RBIT: bit_in = rd_data[bidx];
            FIN_INIT: begin
               count_in     = lim;
               hint_in      = '0;
               hint_base_in = '0;
            end
            default: status_in = ST_OK;
         endcase
      end
   end

   // Control-side registers: configuration, count, pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= TOTAL_RESET;
         count_ff     <= COUNT_RESET;
         word_ff      <= '0;
         base_ff      <= '0;
         hint_ff      <= '0;
         hint_base_ff <= '0;
      end else begin
         if (cfg_we) begin
            total_ff <= cfg_data;
         end
         count_ff     <= count_in;
         hint_ff      <= hint_in;
         hint_base_ff <= hint_base_in;
         if (cmd.clear_start) begin
            word_ff <= '0;
         end else if (cmd.clear_step || cmd.scan_next) begin
            word_ff <= word_ff + ADDR_W'(1);
         end else if (cmd.scan_start) begin
            word_ff <= hint_ff;
         end else if (cmd.div_quot) begin
            word_ff <= ADDR_W'(prod_ff >> DIV_SHIFT);
         end else if (cmd.div_fix && (rem_ff >= REM_W'(WORD_BITS))) begin
            word_ff <= word_ff + ADDR_W'(1);
         end
         if (cmd.scan_start) begin
            base_ff <= hint_base_ff;
         end else if (cmd.scan_next) begin
            base_ff <= base_ff + COUNT_W'(WORD_BITS);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         blk_ff <= req_block;
         bv_ff  <= req_bitval;
      end
      // Quotient estimate by reciprocal; it is exact or one short.
      if (cmd.div_mul) begin
         prod_ff <= PROD_W'(blk_ff) * PROD_W'(RECIP);
      end
      if (cmd.div_rem) begin
         rem_ff <= REM_W'({1'b0, blk_ff} - COUNT_W'(word_ff) * COUNT_W'(WORD_BITS));
      end else if (cmd.div_fix && (rem_ff >= REM_W'(WORD_BITS))) begin
         rem_ff <= rem_ff - REM_W'(WORD_BITS);
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_in;
         rsp_block_ff  <= block_in;
         rsp_bit_ff    <= bit_in;
         rsp_free_ff   <= count_in;
      end
   end

   bba_ram #(
      .WIDTH  (WORD_BITS),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_addr (word_ff),
      .rd_data (rd_data)
   );

   assign rsp_status = rsp_status_ff;
   assign rsp_block  = rsp_block_ff;
   assign rsp_bit    = rsp_bit_ff;
   assign rsp_free   = rsp_free_ff;

endmodule

`default_nettype wire

/* hw/rtl/bba_checker.sv */
// Port-level checker for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg for widths and status codes.
`default_nettype none

module bba_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [bba_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [bba_pkg::STATUS_W-1:0]   rsp_tuser
);

   import bba_pkg::*;

   logic [1:0] pending_ff;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Requests accepted whose responses have not yet been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(req_acc) - 2'(rsp_acc);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pending_ff != 2'd0)
      else $error("response without an outstanding request");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> pending_ff <= 2'd1)
      else $error("request accepted while another is still being worked on");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata[16:0] == 17'd0)
      else $error("error response carries a block number or bit");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire
